// File: rtl/core/mbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and address-map constants for the memory-map decoder.
package mbd_pkg;

  // RAM geometry
  localparam int unsigned MemBytes = 65536;
  localparam int unsigned MemAw    = $clog2(MemBytes);

  // Read decode boundaries
  localparam logic [15:0] AddrRomLo   = 16'h8000;
  localparam logic [15:0] AddrRom8Lo  = 16'hA000;
  localparam logic [15:0] AddrOpenLo  = 16'hC000;
  localparam logic [15:0] AddrIoLo    = 16'hFF00;
  localparam logic [15:0] AddrPort1Lo = 16'hFF20;
  localparam logic [15:0] AddrIoEnd   = 16'hFF40;
  localparam logic [15:0] AddrVecLo   = 16'hFFE0;

  // Write decode pages (address bits 15:5)
  localparam logic [10:0] PagePort0 = 11'h7F8;
  localparam logic [10:0] PagePort1 = 11'h7F9;
  localparam logic [10:0] PageCtrl  = 11'h7FE;

  // Controller register addresses
  localparam logic [15:0] AddrMapClr = 16'hFFDE;
  localparam logic [15:0] AddrMapSet = 16'hFFDF;
  localparam logic [15:0] AddrBaseLo = 16'hFFC6;
  localparam logic [15:0] AddrBaseHi = 16'hFFD3;
  localparam logic [3:0]  BaseBitOfs = 4'd3;

  // Video fetch
  localparam logic [15:0] VideoDefBase = 16'h0400;
  localparam logic [7:0]  OpenBusByte  = 8'hFF;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_VIDEO = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    SRC_RAM     = 3'd0,
    SRC_ROM     = 3'd1,
    SRC_OPEN    = 3'd2,
    SRC_PORT0   = 3'd3,
    SRC_PORT1   = 3'd4,
    SRC_CTRL    = 3'd5,
    SRC_IGNORED = 3'd6,
    SRC_VIDEO   = 3'd7
  } src_e;

  // What the back end has to do with a queued operation
  typedef enum logic [1:0] {
    OP_FIXED  = 2'd0,
    OP_RAM_RD = 2'd1,
    OP_RAM_WR = 2'd2,
    OP_VIDEO  = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    src_e        source;
    logic [7:0]  read_data;
    logic [13:0] rom_offset;
    logic        irq;
    logic        last;
  } op_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/mbd_front.sv
`timescale 1ns / 1ps
// Front end: holds map mode, display base and ROM size, and classifies each beat.
module mbd_front import mbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_data_i,
  input  logic        push_i,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        burst_last_i,
  output op_t         op_o
);

  logic       rom16_q, rom16_d;
  logic       all_ram_q, all_ram_d;
  logic [6:0] base_q, base_d;

  // Fill a ROM-window read: 16K image, upper 8K of an 8K image, else open bus
  function automatic op_t rom_fill(op_t op_in, logic [15:0] a, logic rom16);
    op_t op;
    op = op_in;
    if (rom16) begin
      op.source     = SRC_ROM;
      op.rom_offset = a[13:0];
    end else if (a >= AddrRom8Lo) begin
      op.source     = SRC_ROM;
      op.rom_offset = {1'b0, a[12:0]};
    end else begin
      op.source    = SRC_OPEN;
      op.read_data = OpenBusByte;
    end
    return op;
  endfunction

  // Decode the beat and work out controller register updates
  always_comb begin
    op_t         op;
    logic [15:0] base_addr;
    logic [3:0]  bit_sel;
    logic        ram_ok;
    op            = '0;
    op.addr       = address_i;
    op.wdata      = write_data_i;
    op.kind       = OP_FIXED;
    op.source     = SRC_IGNORED;
    all_ram_d     = all_ram_q;
    base_d        = base_q;
    base_addr     = (base_q != 7'd0) ? {base_q, 9'd0} : VideoDefBase;
    bit_sel       = address_i[4:1] - BaseBitOfs;
    ram_ok        = (address_i < AddrRomLo) || (all_ram_q && (address_i < AddrIoLo));
    case (command_i)
      CMD_READ: begin
        if (ram_ok) begin
          op.kind   = OP_RAM_RD;
          op.source = SRC_RAM;
        end else if (address_i < AddrOpenLo) begin
          op = rom_fill(op, address_i, rom16_q);
        end else if (address_i < AddrIoLo) begin
          op.source    = SRC_OPEN;
          op.read_data = OpenBusByte;
        end else if (address_i < AddrPort1Lo) begin
          op.source = SRC_PORT0;
          op.irq    = ~address_i[0];
        end else if (address_i < AddrIoEnd) begin
          op.source = SRC_PORT1;
          op.irq    = ~address_i[0];
        end else if (address_i >= AddrVecLo) begin
          op = rom_fill(op, address_i, rom16_q);
        end else begin
          op.source    = SRC_OPEN;
          op.read_data = OpenBusByte;
        end
      end
      CMD_WRITE: begin
        if (address_i[15:5] == PagePort0) begin
          op.source = SRC_PORT0;
          op.irq    = address_i[0];
        end else if (address_i[15:5] == PagePort1) begin
          op.source = SRC_PORT1;
          op.irq    = address_i[0];
        end else if (address_i[15:5] == PageCtrl) begin
          op.source = SRC_CTRL;
          if (address_i == AddrMapClr) begin
            all_ram_d = 1'b0;
          end else if (address_i == AddrMapSet) begin
            all_ram_d = 1'b1;
          end
          if ((address_i >= AddrBaseLo) && (address_i <= AddrBaseHi)) begin
            base_d[bit_sel[2:0]] = address_i[0];
          end
        end else if (ram_ok) begin
          op.kind   = OP_RAM_WR;
          op.source = SRC_RAM;
        end else begin
          op.source = SRC_IGNORED;
        end
      end
      CMD_VIDEO: begin
        op.kind   = OP_VIDEO;
        op.source = SRC_VIDEO;
        op.addr   = base_addr + address_i;
        op.last   = burst_last_i;
      end
      default: begin
        op.source = SRC_IGNORED;
      end
    endcase
    op_o = op;
  end

  assign rom16_d = cfg_valid_i ? cfg_data_i : rom16_q;

  // Load ROM size on cfg_valid_i; advance controller state only on accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom16_q   <= 1'b0;
      all_ram_q <= 1'b0;
      base_q    <= 7'd0;
    end else begin
      rom16_q <= rom16_d;
      if (push_i) begin
        all_ram_q <= all_ram_d;
        base_q    <= base_d;
      end
    end
  end

endmodule

// File: rtl/core/mbd_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of decoded operations between front and back end.
module mbd_queue import mbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  op_t     op_i,
  input  logic    pop_i,
  output op_t     head_o,
  output q_stat_t stat_o
);

  op_t        slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Hold payload in the slot until popped
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/mbd_back.sv
`timescale 1ns / 1ps
// Back end: 64 KB RAM with reset clearing sweep, executes operations and registers results.
module mbd_back import mbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_i,
  input  op_t         op_i,
  output logic        clearing_o,
  output logic        done_o,
  output logic [2:0]  source_o,
  output logic [7:0]  read_data_o,
  output logic [13:0] rom_offset_o,
  output logic        irq_recheck_o,
  output logic [9:0]  video_word_o,
  output logic        video_last_o
);

  logic [7:0]       mem_q [MemBytes];
  logic [7:0]       rd_q;
  logic [MemAw-1:0] clr_idx_q;
  logic             clr_q;
  logic             res_vld_q;
  op_t              res_q;
  logic             use_ram;

  assign clearing_o = clr_q;

  // Sweep zeros through the RAM after reset, then serve operations
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_idx_q] <= 8'd0;
    end else if (pop_i && (op_i.kind == OP_RAM_WR)) begin
      mem_q[op_i.addr] <= op_i.wdata;
    end
    rd_q <= mem_q[op_i.addr];
    if (pop_i) begin
      res_q <= op_i;
    end
  end

  // Clear sweep counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == {MemAw{1'b1}}) begin
          clr_q <= 1'b0;
        end
      end
      res_vld_q <= pop_i;
    end
  end

  // Drive the result beat
  assign use_ram       = (res_q.kind == OP_RAM_RD) || (res_q.kind == OP_VIDEO);
  assign done_o        = res_vld_q;
  assign source_o      = res_q.source;
  assign read_data_o   = use_ram ? rd_q : res_q.read_data;
  assign rom_offset_o  = res_q.rom_offset;
  assign irq_recheck_o = res_q.irq;
  assign video_word_o  = (res_q.kind == OP_VIDEO) ? {rd_q[7:6], rd_q} : 10'd0;
  assign video_last_o  = res_q.last;

endmodule

// File: rtl/core/mapped_bus_decoder_with_ram.sv
`timescale 1ns / 1ps
// Top level of the memory-map decoder with 64 KB of RAM.
// After reset the block zeroes its RAM one byte per clock and holds busy high
// until the sweep ends; configuration writes are taken during that time. Then one
// command beat is taken per clock whenever busy is low, and each beat produces
// exactly one result beat, marked by done_o for a single cycle, after it passes
// through the queue slot and the result register, in order. The pace is set by
// the single RAM port: one read or write per clock. Results cannot be held off,
// so sample them when done_o is high. ROM and peripheral data are not supplied
// here: source_o and rom_offset_o tell the system where to fetch them.
module mapped_bus_decoder_with_ram import mbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_rom_is_16k_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        burst_last_i,
  output logic        done_o,
  output logic [2:0]  source_o,
  output logic [7:0]  read_data_o,
  output logic [13:0] rom_offset_o,
  output logic        irq_recheck_o,
  output logic [9:0]  video_word_o,
  output logic        video_last_o
);

  op_t     front_op;
  op_t     head_op;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    clearing;

  // Accept a beat when there is room and the RAM sweep is done
  assign cfg_ready_o = 1'b1;
  assign busy        = clearing || q_stat.full;
  assign push        = start && !busy;
  assign pop         = !q_stat.empty && !clearing;

  mbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_rom_is_16k_i),
    .push_i       (push),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .burst_last_i (burst_last_i),
    .op_o         (front_op)
  );

  mbd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .pop_i  (pop),
    .head_o (head_op),
    .stat_o (q_stat)
  );

  mbd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_i         (pop),
    .op_i          (head_op),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .source_o      (source_o),
    .read_data_o   (read_data_o),
    .rom_offset_o  (rom_offset_o),
    .irq_recheck_o (irq_recheck_o),
    .video_word_o  (video_word_o),
    .video_last_o  (video_last_o)
  );

endmodule
